// ===== src/tstmf_pkg.sv =====
package tstmf_pkg;

  // Width of every coordinate value the block stores or returns
  localparam int VALUE_BITS = 12;

  // Converter samples that arrive with each transaction
  localparam int INPUT_SAMPLES = 4;
  localparam int SEL_BITS = $clog2(INPUT_SAMPLES);

  // Reset value of the spread limit
  localparam logic [VALUE_BITS-1:0] SPREAD_RESET = 12'd5;

  typedef logic [VALUE_BITS-1:0] value_t;

  // Outcome of the median-pair stage for one reading
  typedef struct packed {
    logic   within_spread;  // middle pair close enough to trust
    value_t avg;            // floor average of the middle pair
  } median_result_t;

endpackage

// ===== src/tstmf_median.sv =====
module tstmf_median #(
  parameter int SAMPLE_COUNT = 4,
  parameter int SAMPLE_BITS  = 12
) (
  input  tstmf_pkg::value_t         samples [tstmf_pkg::INPUT_SAMPLES],
  input  tstmf_pkg::value_t         max_spread,
  output tstmf_pkg::median_result_t result
);
  import tstmf_pkg::*;

  // Effective sample width after masking; inputs carry VALUE_BITS at most
  localparam int SW = (SAMPLE_BITS < VALUE_BITS) ? SAMPLE_BITS : VALUE_BITS;
  localparam int RW = $clog2(SAMPLE_COUNT);
  localparam logic [RW-1:0] LO_RANK = RW'(SAMPLE_COUNT / 2 - 1);
  localparam logic [RW-1:0] HI_RANK = RW'(SAMPLE_COUNT / 2);

  logic [SW-1:0] slot [SAMPLE_COUNT];
  logic [RW-1:0] rank [SAMPLE_COUNT];
  logic [SW-1:0] lo;
  logic [SW-1:0] hi;
  logic [SW-1:0] diff;
  logic [SW:0]   sum;

  // Fill sort slots, slot i takes sample i mod INPUT_SAMPLES
  always_comb begin
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      slot[i] = samples[SEL_BITS'(i % INPUT_SAMPLES)][SW-1:0];
    end
  end

  // Sorted position of each slot; ties broken by slot order so ranks are unique
  always_comb begin
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      rank[i] = '0;
      for (int j = 0; j < SAMPLE_COUNT; j++) begin
        if ((slot[j] < slot[i]) || ((slot[j] == slot[i]) && (j < i))) begin
          rank[i] = rank[i] + RW'(1);
        end
      end
    end
  end

  // Pick the two middle values
  always_comb begin
    lo = '0;
    hi = '0;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      if (rank[i] == LO_RANK) begin
        lo = slot[i];
      end
      if (rank[i] == HI_RANK) begin
        hi = slot[i];
      end
    end
  end

  // Spread check and floor average
  assign diff = hi - lo;
  assign sum  = {1'b0, hi} + {1'b0, lo};

  assign result.within_spread = (VALUE_BITS'(diff) <= max_spread);
  assign result.avg           = VALUE_BITS'(sum[SW:1]);

endmodule

// ===== src/touch_sample_trimmed_mean_filter.sv =====
// Trimmed-mean filter for touch-panel converter readings.
// Input channel: in_valid / in_stall carry pen_down, channel_is_y and four
// samples. Output channel: out_valid / out_stall carry filtered_value. A
// transaction moves at a clock edge with valid high and stall low.
// Every input transaction yields exactly one output transaction.
// Pen up gives 0. Pen down sorts the samples, takes the middle pair and, if
// their difference is at most max_spread, stores and returns their floor
// average for the selected channel; otherwise returns that channel's held value.
// An input transaction passes the input register, then the result register,
// before it leaves as an output transaction. Throughput: one transaction per
// cycle while out_stall is low, set by the combinational rank-and-select
// network between the two registers.
// cfg_wr_en / cfg_wr_data write max_spread; write only while the block is idle.
// Reset (rst, synchronous): both pipeline stages empty, held values 0,
// max_spread 5. When out_stall is high the result register holds and the
// input register keeps taking one more transaction, then in_stall rises.
module touch_sample_trimmed_mean_filter #(
  parameter int SAMPLE_COUNT = 4,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  tstmf_pkg::value_t cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              pen_down,
  input  logic              channel_is_y,
  input  tstmf_pkg::value_t sample_a,
  input  tstmf_pkg::value_t sample_b,
  input  tstmf_pkg::value_t sample_c,
  input  tstmf_pkg::value_t sample_d,
  output logic              out_valid,
  input  logic              out_stall,
  output tstmf_pkg::value_t filtered_value
);
  import tstmf_pkg::*;

  value_t         max_spread;
  logic           s1_valid;
  logic           s1_pen;
  logic           s1_is_y;
  value_t         s1_samples [INPUT_SAMPLES];
  value_t         held_y;
  value_t         held_other;
  logic           advance;
  logic           in_take;
  median_result_t med;
  value_t         held_sel;
  value_t         result_next;
  logic           store;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_spread <= SPREAD_RESET;
    end else if (cfg_wr_en) begin
      max_spread <= cfg_wr_data;
    end
  end

  // Handshake: stage 1 moves on when the result register is free or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pen        <= pen_down;
      s1_is_y       <= channel_is_y;
      s1_samples[0] <= sample_a;
      s1_samples[1] <= sample_b;
      s1_samples[2] <= sample_c;
      s1_samples[3] <= sample_d;
    end
  end

  // Middle pair, spread check and average
  tstmf_median #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_median (
    .samples    (s1_samples),
    .max_spread (max_spread),
    .result     (med)
  );

  // Result select
  assign held_sel = s1_is_y ? held_y : held_other;
  assign store    = s1_pen && med.within_spread;

  always_comb begin
    if (!s1_pen) begin
      result_next = '0;
    end else if (med.within_spread) begin
      result_next = med.avg;
    end else begin
      result_next = held_sel;
    end
  end

  // Held values update as the transaction leaves stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      held_y     <= '0;
      held_other <= '0;
    end else if (advance && store) begin
      if (s1_is_y) begin
        held_y <= med.avg;
      end else begin
        held_other <= med.avg;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filtered_value <= result_next;
    end
  end

  // Pen-up readings always come out as zero
  assert property (@(posedge clk) disable iff (rst)
    (advance && !s1_pen) |=> (out_valid && (filtered_value == '0)))
    else $error("pen-up transaction did not produce zero");

  // Held values change only when a transaction leaves stage 1
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(held_y) && $stable(held_other)))
    else $error("held value changed without a transaction");

  // A rejected reading leaves both held values alone
  assert property (@(posedge clk) disable iff (rst)
    (advance && !store) |=> ($stable(held_y) && $stable(held_other)))
    else $error("held value changed on a rejected reading");

  // Input side stalls only while stage 1 is occupied
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty stage 1");

  // Reset empties both stages
  assert property (@(posedge clk)
    rst |=> (!s1_valid && !out_valid))
    else $error("pipeline not empty after reset");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import tstmf_pkg::*;

  localparam int IDLE_LIMIT = 3000;  // cycles without any transaction
  localparam int SETTLE_CYCLES = 6;  // settle time after draining, for the two-stage pipeline

  // One reading as it enters the filter
  typedef struct packed {
    logic             pen_down;
    logic             channel_is_y;
    value_t [3:0]     samples;
  } reading_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_wr_en = 1'b0;
  value_t cfg_wr_data = '0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   pen_down = 1'b0;
  logic   channel_is_y = 1'b0;
  value_t sample_a = '0;
  value_t sample_b = '0;
  value_t sample_c = '0;
  value_t sample_d = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  value_t filtered_value;

  // Predictor state: spread limit and the two held coordinates
  value_t spread_limit;
  value_t held_y;
  value_t held_other;
  value_t pending_filtered[$];

  int error_count = 0;
  int readings_sent = 0;
  int results_checked = 0;
  int pen_up_count = 0;
  int rejected_count = 0;
  int averaged_count = 0;
  int limits_written = 0;
  int idle_cycles = 0;
  bit run_done = 1'b0;

  // Receiver behavior controls
  bit rx_idle = 1'b0;
  bit tx_gaps = 1'b0;
  int hold_count = 0;
  int stall_left = 0;

  touch_sample_trimmed_mean_filter dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pen_down       (pen_down),
    .channel_is_y   (channel_is_y),
    .sample_a       (sample_a),
    .sample_b       (sample_b),
    .sample_c       (sample_c),
    .sample_d       (sample_d),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_value (filtered_value)
  );

  always #4 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int rand_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Trimmed mean of one reading; updates the held coordinate when accepted
  function automatic value_t filter_reading(reading_t r);
    value_t v [4];
    value_t t;
    value_t lo;
    value_t hi;
    logic [VALUE_BITS:0] pair_sum;
    for (int i = 0; i < 4; i++) v[i] = r.samples[i];
    if (!r.pen_down) begin
      pen_up_count++;
      return '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = i + 1; j < 4; j++) begin
        if (v[i] > v[j]) begin
          t = v[i];
          v[i] = v[j];
          v[j] = t;
        end
      end
    end
    lo = v[1];
    hi = v[2];
    if (hi - lo > spread_limit) begin
      rejected_count++;
      return r.channel_is_y ? held_y : held_other;
    end
    averaged_count++;
    pair_sum = {1'b0, hi} + {1'b0, lo};
    if (r.channel_is_y) held_y = pair_sum[VALUE_BITS:1];
    else held_other = pair_sum[VALUE_BITS:1];
    return pair_sum[VALUE_BITS:1];
  endfunction

  function automatic reading_t make_reading(logic pen, logic y, value_t a, value_t b,
                                            value_t c, value_t d);
    reading_t r;
    r.pen_down = pen;
    r.channel_is_y = y;
    r.samples = {d, c, b, a};
    return r;
  endfunction

  // Mostly clustered readings whose middle pair lands near the limit,
  // plus outliers and fully random noise
  function automatic reading_t random_reading();
    reading_t r;
    int base;
    int reach;
    int s;
    r.pen_down = ($urandom_range(0, 9) != 0);
    r.channel_is_y = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < 4; i++) r.samples[i] = value_t'($urandom_range(0, 4095));
    end else begin
      base = $urandom_range(0, 4095);
      reach = int'(spread_limit) + 2;
      for (int i = 0; i < 4; i++) begin
        s = base + int'($urandom_range(0, reach)) - reach / 2;
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
        r.samples[i] = value_t'(s);
      end
      if ($urandom_range(0, 2) == 0) begin
        r.samples[2'($urandom_range(0, 3))] = value_t'($urandom_range(0, 4095));
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, value_t got, value_t want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Offer one reading and hold it until the filter takes it
  task automatic send_reading(reading_t r);
    in_valid <= 1'b1;
    pen_down <= r.pen_down;
    channel_is_y <= r.channel_is_y;
    sample_a <= r.samples[0];
    sample_b <= r.samples[1];
    sample_c <= r.samples[2];
    sample_d <= r.samples[3];
    do @(posedge clk); while (in_stall);
    pending_filtered.push_back(filter_reading(r));
    readings_sent++;
    @(negedge clk);
  endtask

  task automatic idle_sender(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Sender pauses until every expected result has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_filtered.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_spread(value_t limit);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= limit;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    spread_limit = limit;
    limits_written++;
  endtask

  task automatic run_random(int count);
    repeat (count) begin
      send_reading(random_reading());
      if (tx_gaps) idle_sender(rand_gap());
    end
  endtask

  // Extremes, pen up, spread at and just over the reset limit, floor average
  task automatic test_directed();
    tx_gaps = 1'b0;
    rx_idle = 1'b0;
    send_reading(make_reading(1'b0, 1'b0, 12'd4095, 12'd4095, 12'd4095, 12'd4095));
    send_reading(make_reading(1'b0, 1'b1, 12'd0, 12'd0, 12'd0, 12'd0));
    send_reading(make_reading(1'b1, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0));
    send_reading(make_reading(1'b1, 1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095));
    send_reading(make_reading(1'b1, 1'b0, 12'd4095, 12'd0, 12'd2000, 12'd2001));
    send_reading(make_reading(1'b1, 1'b0, 12'd10, 12'd3000, 12'd3005, 12'd4095));
    send_reading(make_reading(1'b1, 1'b0, 12'd3000, 12'd3006, 12'd0, 12'd4095));
    send_reading(make_reading(1'b1, 1'b1, 12'd100, 12'd106, 12'd50, 12'd200));
    send_reading(make_reading(1'b0, 1'b1, 12'h555, 12'hAAA, 12'h555, 12'hAAA));
    send_reading(make_reading(1'b1, 1'b1, 12'd2048, 12'd2047, 12'd0, 12'd4095));
    send_reading(make_reading(1'b1, 1'b0, 12'd4095, 12'd1, 12'd1, 12'd1));
    send_reading(make_reading(1'b1, 1'b0, 12'd4090, 12'd4095, 12'd4095, 12'd0));
    send_reading(make_reading(1'b1, 1'b1, 12'hAAA, 12'hAAA, 12'h555, 12'h555));
    send_reading(make_reading(1'b1, 1'b1, 12'hAAA, 12'hAAA, 12'hAAB, 12'h555));
    send_reading(make_reading(1'b1, 1'b0, 12'h555, 12'h555, 12'h556, 12'hFFF));
    wait_drained();
  endtask

  // Zero limit, full-range limit and a small one
  task automatic test_spread_limits();
    write_spread(12'd0);
    tx_gaps = 1'b0;
    rx_idle = 1'b0;
    send_reading(make_reading(1'b1, 1'b0, 12'd7, 12'd9, 12'd7, 12'd3));
    send_reading(make_reading(1'b1, 1'b0, 12'd7, 12'd8, 12'd0, 12'd9));
    tx_gaps = 1'b1;
    rx_idle = 1'b1;
    run_random(35);
    write_spread(12'd4095);
    send_reading(make_reading(1'b1, 1'b1, 12'd0, 12'd0, 12'd4095, 12'd4095));
    run_random(35);
    write_spread(12'd1);
    run_random(35);
  endtask

  // Several random limits, with and without idling on either side
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase % 2 == 0) write_spread(value_t'($urandom_range(0, 32)));
      else write_spread(value_t'($urandom_range(0, 4095)));
      tx_gaps = (phase % 3 != 2);
      rx_idle = (phase % 3 != 1);
      run_random(40);
    end
  endtask

  // Long receiver hold while the sender keeps offering back to back
  task automatic test_backpressure();
    write_spread(value_t'($urandom_range(2, 40)));
    tx_gaps = 1'b0;
    rx_idle = 1'b0;
    hold_count = 80;
    run_random(24);
    wait_drained();
    rx_idle = 1'b1;
    tx_gaps = 1'b1;
    run_random(12);
    wait_drained();
  endtask

  // Result receiver: random stalls plus the requested long hold
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_count > 0) begin
      out_stall <= 1'b1;
      hold_count--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (rx_idle && $urandom_range(0, 3) == 0) stall_left = rand_gap();
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_filtered.size() == 0) begin
        report_mismatch("unexpected filtered_value", filtered_value, '0);
      end else begin
        if (filtered_value !== pending_filtered[0])
          report_mismatch("filtered_value", filtered_value, pending_filtered[0]);
        void'(pending_filtered.pop_front());
        results_checked++;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst && !run_done) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    spread_limit = SPREAD_RESET;
    held_y = '0;
    held_other = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_spread_limits();
    test_random_traffic();
    test_backpressure();
    wait_drained();
    run_done = 1'b1;
    $display("covered %0d readings: %0d pen up, %0d over the spread limit, %0d averaged",
             readings_sent, pen_up_count, rejected_count, averaged_count);
    $display("%0d spread limits written, %0d results compared, %0d mismatches",
             limits_written, results_checked, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tstmf_pkg.sv
src/tstmf_median.sv
src/touch_sample_trimmed_mean_filter.sv
tb/sv/testbench.sv
